[hw/rtl/sapf_pkg.sv]
package sapf_pkg;

  localparam int unsigned TableEntries = 8;

  localparam logic [1:0] OpCheck  = 2'd0;
  localparam logic [1:0] OpAdd    = 2'd1;
  localparam logic [1:0] OpMode   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StDup  = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StSame = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic        new_mode;
  } req_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [7:0]  protocol;
    logic [31:0] addr;
    logic [15:0] port;
    logic        same;
    logic        hit;
    logic        written;
  } token_t;

endpackage

[hw/rtl/sapf_cell.sv]
module sapf_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  sapf_pkg::token_t tok_i,
  output sapf_pkg::token_t tok_o
);

  logic             valid_q, valid_d;
  logic [31:0]      addr_q;
  logic [15:0]      port_q;
  sapf_pkg::token_t tok_q, tok_d;
  logic             match;
  logic             wr_en;

  assign match = valid_q && (addr_q == tok_i.addr) && (port_q == tok_i.port);
  assign wr_en = tok_i.vld && (tok_i.op == sapf_pkg::OpAdd) && !tok_i.hit
                 && !tok_i.written && !valid_q;

  always_comb begin
    tok_d         = tok_i;
    tok_d.hit     = tok_i.hit | match;
    tok_d.written = tok_i.written | wr_en;
    valid_d       = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (wr_en) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      addr_q <= tok_i.addr;
      port_q <= tok_i.port;
    end
  end

  assign tok_o = tok_q;

endmodule

[hw/rtl/source_address_port_filter_core.sv]
// Source address and port filter. A transaction is taken when start is high
// and busy is low; busy then stays high until the result appears. Every
// transaction walks the row of table cells, one cell per cycle; its
// result is shown on rsp_o with done_o high for one cycle, and busy falls
// in that same cycle, so the next transaction may start then. The
// receiver cannot stall: done_o is not held, and rsp_o keeps a result
// only until the next one. Non TCP/UDP packets are always accepted; a
// mode change empties the table; an add that matches no entry in a full
// table reports full and changes nothing.
module source_address_port_filter_core #(
  parameter int unsigned TableEntries = sapf_pkg::TableEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sapf_pkg::req_t req_i,
  output logic           done_o,
  output sapf_pkg::rsp_t rsp_o
);

  sapf_pkg::token_t tok [TableEntries+1];
  sapf_pkg::token_t tok_last;
  sapf_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q;
  logic             busy_q, busy_d;
  logic             mode_q, mode_d;
  logic             take;
  logic             clear;
  logic             is_ip;

  assign take  = start && !busy_q;
  assign clear = take && (req_i.op == sapf_pkg::OpMode) && (req_i.new_mode != mode_q);

  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = take;
    tok[0].op       = req_i.op;
    tok[0].protocol = req_i.protocol;
    tok[0].addr     = req_i.src_addr;
    tok[0].port     = req_i.src_port;
    tok[0].same     = (req_i.new_mode == mode_q);
  end

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    sapf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clear_i(clear),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign tok_last = tok[TableEntries];
  assign is_ip    = (tok_last.protocol == sapf_pkg::ProtoTcp)
                 || (tok_last.protocol == sapf_pkg::ProtoUdp);

  always_comb begin
    rsp_d = '0;
    case (tok_last.op)
      sapf_pkg::OpCheck: begin
        if (!is_ip) begin
          rsp_d.accept = 1'b1;
        end else begin
          rsp_d.accept = mode_q ? tok_last.hit : !tok_last.hit;
        end
      end
      sapf_pkg::OpAdd: begin
        if (tok_last.hit) begin
          rsp_d.status = sapf_pkg::StDup;
        end else if (tok_last.written) begin
          rsp_d.status = sapf_pkg::StDone;
        end else begin
          rsp_d.status = sapf_pkg::StFull;
        end
      end
      sapf_pkg::OpMode: begin
        rsp_d.status = tok_last.same ? sapf_pkg::StSame : sapf_pkg::StDone;
      end
      default: rsp_d = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (take) begin
      busy_d = 1'b1;
    end else if (tok_last.vld) begin
      busy_d = 1'b0;
    end
    mode_d = clear ? req_i.new_mode : mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mode_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mode_q <= mode_d;
      done_q <= tok_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_last.vld) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[hw/rtl/sapf_checker.sv]
module sapf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input sapf_pkg::rsp_t rsp_o
);

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a transaction was taken");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.accept |-> rsp_o.status == sapf_pkg::StDone)
    else $error("accept with a non-done status");

endmodule

bind source_address_port_filter_core sapf_checker u_sapf_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
